@@ src/rmst_pkg.sv @@
// ---------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants for the range-minimum segment tree unit.
// ---------------------------------------------------------------------------
package rmst_pkg;

   localparam int LEAVES_DEFAULT = 1024;
   localparam int POS_W          = 10;
   localparam int VAL_W          = 32;
   localparam int CNT_W          = 11;
   localparam int CSR_IDX_W      = 1;

   localparam logic signed [VAL_W-1:0] RESET_NODE_VALUE = 32'sd99999;
   localparam logic [CNT_W-1:0]        ACTIVE_RESET     = 11'd1024;
   localparam logic signed [VAL_W-1:0] EMPTY_RESET      = 32'sd99999;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_VALUE  = 1'b1;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] range_min;
      logic                    bad_request;
   } result_type;

   function automatic logic signed [VAL_W-1:0] smin(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

endpackage

@@ src/rmst_ram.sv @@
// ---------------------------------------------------------------------------
// rmst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module rmst_ram #(
   parameter int Width = 32,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   output logic [Width-1:0]         rd_data_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

@@ src/rmst_ctrl.sv @@
// ---------------------------------------------------------------------------
// rmst_ctrl
// Sequencer: clear pass, leaf-to-root update walk, bottom-up query walk.
// ---------------------------------------------------------------------------
module rmst_ctrl #(
   parameter int Leaves = rmst_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rmst_pkg::CNT_W-1:0]          active_count,
   input  logic signed [rmst_pkg::VAL_W-1:0]   empty_value,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                kind,
   input  logic [rmst_pkg::POS_W-1:0]          first_position,
   input  logic [rmst_pkg::POS_W-1:0]          last_position,
   input  logic signed [rmst_pkg::VAL_W-1:0]   new_value,
   output logic                                res_valid,
   input  logic                                res_ready,
   output rmst_pkg::result_type                res,
   output logic                                mem_wr_en,
   output logic [$clog2(2*Leaves)-1:0]         mem_wr_addr,
   output logic signed [rmst_pkg::VAL_W-1:0]   mem_wr_data,
   output logic [$clog2(2*Leaves)-1:0]         mem_rd_addr_a,
   input  logic signed [rmst_pkg::VAL_W-1:0]   mem_rd_data_a,
   output logic [$clog2(2*Leaves)-1:0]         mem_rd_addr_b,
   input  logic signed [rmst_pkg::VAL_W-1:0]   mem_rd_data_b
);
   import rmst_pkg::*;

   localparam int NW = $clog2(2*Leaves);
   localparam int WW = NW + 1;
   localparam int CW = (NW > CNT_W) ? NW : CNT_W;

   state_type state_ff, state_in;
   logic [NW-1:0]           clr_ff, clr_in;
   logic [NW-1:0]           idx_ff, idx_in;
   logic signed [VAL_W-1:0] cur_ff, cur_in;
   logic [WW-1:0]           lo_ff, lo_in;
   logic [WW-1:0]           hi_ff, hi_in;
   logic signed [VAL_W-1:0] acc_ff, acc_in;
   logic                    have_ff, have_in;
   logic                    pend_a_ff, pend_a_in;
   logic                    pend_b_ff, pend_b_in;
   result_type              res_ff, res_in;

   logic [CW-1:0]           limit;
   logic [NW-1:0]           leaf;
   logic [NW-1:0]           parent;
   logic signed [VAL_W-1:0] upd_min;
   logic signed [VAL_W-1:0] pair;
   logic signed [VAL_W-1:0] new_acc;
   logic                    new_have;
   logic [WW-1:0]           lo_step;
   logic [WW-1:0]           hi_m1;
   logic [WW-1:0]           hi_step;
   logic                    bad_upd;
   logic                    bad_qry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
         have_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
         have_ff   <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   always_comb begin
      limit = (CW'(active_count) > CW'(Leaves)) ? CW'(Leaves) : CW'(active_count);
      bad_upd = CW'(first_position) >= limit;
      bad_qry = (first_position > last_position) || (CW'(last_position) >= limit);
      leaf    = NW'(Leaves) + NW'(first_position);
      parent  = idx_ff >> 1;
      upd_min = smin(cur_ff, mem_rd_data_a);

      if (pend_a_ff && pend_b_ff) begin
         pair = smin(mem_rd_data_a, mem_rd_data_b);
      end else if (pend_a_ff) begin
         pair = mem_rd_data_a;
      end else begin
         pair = mem_rd_data_b;
      end
      if (!(pend_a_ff || pend_b_ff)) begin
         new_acc = acc_ff;
      end else if (have_ff) begin
         new_acc = smin(acc_ff, pair);
      end else begin
         new_acc = pair;
      end
      new_have = have_ff | pend_a_ff | pend_b_ff;

      lo_step = lo_ff + WW'(lo_ff[0]);
      hi_m1   = hi_ff - WW'(1);
      hi_step = hi_ff - WW'(hi_ff[0]);

      state_in  = state_ff;
      clr_in    = clr_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      acc_in    = acc_ff;
      have_in   = have_ff;
      pend_a_in = 1'b0;
      pend_b_in = 1'b0;
      res_in    = res_ff;

      req_ready     = 1'b0;
      res_valid     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = clr_ff;
      mem_wr_data   = RESET_NODE_VALUE;
      mem_rd_addr_a = lo_ff[NW-1:0];
      mem_rd_addr_b = hi_m1[NW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + NW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            mem_wr_addr   = leaf;
            mem_wr_data   = new_value;
            mem_rd_addr_a = leaf ^ NW'(1);
            if (req_valid) begin
               if (kind == KIND_UPDATE) begin
                  if (bad_upd) begin
                     res_in   = '{range_min: empty_value, bad_request: 1'b1};
                     state_in = ST_REPLY;
                  end else begin
                     mem_wr_en = 1'b1;
                     idx_in    = leaf;
                     cur_in    = new_value;
                     state_in  = ST_UPDATE;
                  end
               end else begin
                  if (bad_qry) begin
                     res_in   = '{range_min: empty_value, bad_request: 1'b1};
                     state_in = ST_REPLY;
                  end else begin
                     lo_in    = WW'(Leaves) + WW'(first_position);
                     hi_in    = WW'(Leaves) + WW'(last_position) + WW'(1);
                     have_in  = 1'b0;
                     state_in = ST_QUERY;
                  end
               end
            end
         end
         ST_UPDATE: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = parent;
            mem_wr_data   = upd_min;
            mem_rd_addr_a = parent ^ NW'(1);
            cur_in        = upd_min;
            idx_in        = parent;
            if (parent == NW'(1)) begin
               res_in   = '{range_min: empty_value, bad_request: 1'b0};
               state_in = ST_REPLY;
            end
         end
         ST_QUERY: begin
            acc_in  = new_acc;
            have_in = new_have;
            if (lo_ff < hi_ff) begin
               pend_a_in = lo_ff[0];
               pend_b_in = hi_ff[0];
               lo_in     = lo_step >> 1;
               hi_in     = hi_step >> 1;
            end else begin
               res_in   = '{range_min: (new_have ? new_acc : empty_value),
                            bad_request: 1'b0};
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

@@ src/range_minimum_segment_tree_unit.sv @@
// Throughput: one request at a time; the next request is taken the cycle after the previous
// result has moved to the output register, set by the one-level-per-cycle walk over node RAM.
// Reset: synchronous; a clearing pass writes every node to 99999, during which no request
// is taken. Configuration writes are taken at any time.
// ---------------------------------------------------------------------------
// range_minimum_segment_tree_unit
// Min segment tree with point updates and inclusive range-minimum queries.
// ---------------------------------------------------------------------------
module range_minimum_segment_tree_unit #(
   parameter int Leaves = rmst_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [55:0]                         req_tdata,  // first_position, last_position, new_value
   input  logic [0:0]                          req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // range_min
   output logic [0:0]                          rsp_tuser,  // bad_request
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data
);
   import rmst_pkg::*;

   localparam int NW = $clog2(2*Leaves);

   logic [CNT_W-1:0]        active_count_ff;
   logic signed [VAL_W-1:0] empty_value_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   logic                    res_valid;
   logic                    res_ready;
   result_type              res;
   logic                    mem_wr_en;
   logic [NW-1:0]           mem_wr_addr;
   logic signed [VAL_W-1:0] mem_wr_data;
   logic [NW-1:0]           mem_rd_addr_a;
   logic signed [VAL_W-1:0] mem_rd_data_a;
   logic [NW-1:0]           mem_rd_addr_b;
   logic signed [VAL_W-1:0] mem_rd_data_b;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= ACTIVE_RESET;
         empty_value_ff  <= EMPTY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_COUNT: active_count_ff <= csr_data[CNT_W-1:0];
            CSR_EMPTY_VALUE:  empty_value_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   rmst_ctrl #(
      .Leaves(Leaves)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .active_count  (active_count_ff),
      .empty_value   (empty_value_ff),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .kind          (req_tuser[0]),
      .first_position(req_tdata[9:0]),
      .last_position (req_tdata[19:10]),
      .new_value     (req_tdata[51:20]),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_data_a (mem_rd_data_a),
      .mem_rd_addr_b (mem_rd_addr_b),
      .mem_rd_data_b (mem_rd_data_b)
   );

   rmst_ram #(
      .Width(VAL_W),
      .Depth(2*Leaves)
   ) u_node_ram (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_addr_a(mem_rd_addr_a),
      .rd_data_a(mem_rd_data_a),
      .rd_addr_b(mem_rd_addr_b),
      .rd_data_b(mem_rd_data_b)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff.range_min;
   assign rsp_tuser[0] = rsp_ff.bad_request;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for range_minimum_segment_tree_unit. A scoreboard keeps a flat
// copy of the element array and the two settings, predicts each response at
// the request handshake and checks responses in order. Directed requests
// cover range and value extremes, unloaded elements and every error case;
// random phases run with various sender/receiver idling and settings.
// ---------------------------------------------------------------------------
module tb;
   import rmst_pkg::*;

   localparam int NUM_ELEMENTS  = LEAVES_DEFAULT;
   localparam int RANDOM_PER_PHASE = 128;

   class range_min_scoreboard;
      logic signed [VAL_W-1:0] element [NUM_ELEMENTS];
      logic [CNT_W-1:0]        active_count;
      logic signed [VAL_W-1:0] empty_value;
      result_type              pending_q[$];
      int unsigned             errors;

      function new();
         foreach (element[i]) element[i] = RESET_NODE_VALUE;
         active_count = ACTIVE_RESET;
         empty_value  = EMPTY_RESET;
         errors       = 0;
      endfunction

      function int unsigned usable_count();
         return (active_count > NUM_ELEMENTS) ? NUM_ELEMENTS : active_count;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
         if (index == CSR_ACTIVE_COUNT)
            active_count = data[CNT_W-1:0];
         else if (index == CSR_EMPTY_VALUE)
            empty_value = data;
      endfunction

      function void note_request(logic kind, logic [POS_W-1:0] first,
                                 logic [POS_W-1:0] last, logic signed [VAL_W-1:0] value);
         result_type              r;
         int unsigned             limit;
         logic signed [VAL_W-1:0] m;
         limit         = usable_count();
         r.range_min   = empty_value;
         r.bad_request = 1'b0;
         if (kind == KIND_UPDATE) begin
            if (first >= limit)
               r.bad_request = 1'b1;
            else
               element[first] = value;
         end else if (first > last || last >= limit) begin
            r.bad_request = 1'b1;
         end else begin
            m = element[first];
            for (int p = first + 1; p <= last; p++)
               if (element[p] < m) m = element[p];
            r.range_min = m;
         end
         pending_q.push_back(r);
      endfunction

      function void check_response(logic [VAL_W-1:0] data, logic bad);
         result_type r;
         if (pending_q.size() == 0) begin
            $display("%0t: response with no request pending: range_min %0d bad_request %0b",
                     $time, $signed(data), bad);
            errors++;
            return;
         end
         r = pending_q.pop_front();
         if (data !== r.range_min) begin
            $display("%0t: range_min mismatch: expected %0d, actual %0d",
                     $time, r.range_min, $signed(data));
            errors++;
         end
         if (bad !== r.bad_request) begin
            $display("%0t: bad_request mismatch: expected %0b, actual %0b",
                     $time, r.bad_request, bad);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [55:0]          req_tdata = '0;  // first_position, last_position, new_value
   logic [0:0]           req_tuser = '0;  // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;       // range_min
   logic [0:0]           rsp_tuser;       // bad_request
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   range_min_scoreboard sb;

   range_minimum_segment_tree_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser[0]);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(input logic kind, input logic [POS_W-1:0] first,
                               input logic [POS_W-1:0] last,
                               input logic signed [VAL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, value, last, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, first, last, value);
   endtask

   task automatic update(input int unsigned pos, input logic signed [VAL_W-1:0] value);
      send_request(KIND_UPDATE, pos[POS_W-1:0], POS_W'($urandom), value);
   endtask

   task automatic query(input int unsigned first, input int unsigned last);
      send_request(KIND_QUERY, first[POS_W-1:0], last[POS_W-1:0], VAL_W'($urandom));
   endtask

   // sender holds off until all responses are back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic configure(input logic [CNT_W-1:0] count, input logic signed [VAL_W-1:0] empty);
      drain();
      write_csr(CSR_ACTIVE_COUNT, 32'(count));
      write_csr(CSR_EMPTY_VALUE, empty);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25)
         return VAL_W'($urandom);
      if (roll < 50)
         case ($urandom_range(6))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd99999;
            3: return 32'sd99998;
            4: return 32'sd100000;
            5: return 32'sd0;
            default: return -32'sd1;
         endcase
      return $signed(VAL_W'($urandom_range(200000))) - 32'sd100000;
   endfunction

   task automatic random_request();
      int unsigned usable;
      int unsigned roll;
      int unsigned first;
      int unsigned last;
      int unsigned span;
      logic        kind;
      usable = sb.usable_count();
      kind   = 1'($urandom_range(1));
      roll   = $urandom_range(99);
      if (usable == 0 || roll < 8) begin
         first = $urandom_range(NUM_ELEMENTS - 1);
         last  = $urandom_range(NUM_ELEMENTS - 1);
      end else begin
         first = $urandom_range(usable - 1);
         if (roll < 55) begin
            span = $urandom_range(15);
            last = (first + span < usable) ? first + span : usable - 1;
         end else begin
            last = $urandom_range(usable - 1, first);
         end
         if (roll < 14 && first != last) begin
            int unsigned t;
            t = first; first = last; last = t;
         end
      end
      if (kind == KIND_UPDATE)
         update(first, pick_value());
      else
         query(first, last);
   endtask

   task automatic random_phase(input int unsigned s_pct, input int unsigned r_pct,
                               input logic [CNT_W-1:0] count,
                               input logic signed [VAL_W-1:0] empty);
      configure(count, empty);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         random_request();
         if (i == RANDOM_PER_PHASE / 2) drain();
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 31;
      recv_idle_pct = 51;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings, unloaded elements, value extremes
      query(0, 1023);
      update(0, 32'sh8000_0000);
      update(1023, 32'sh7FFF_FFFF);
      update(512, 32'sd0);
      update(5, -32'sd1);
      query(0, 0);
      query(1023, 1023);
      query(0, 1023);
      query(1, 1022);
      query(6, 511);
      query(10, 9);

      // reduced active count
      configure(11'd100, 32'sh8000_0000);
      update(100, 32'sd7);
      query(0, 100);
      query(99, 99);
      update(99, -32'sd5);
      query(0, 99);
      query(6, 99);

      // zero active count: everything invalid
      configure(11'd0, 32'sh7FFF_FFFF);
      update(0, 32'sd1);
      query(0, 0);

      // oversize active count saturates
      configure(11'd2047, 32'sd99999);
      query(0, 1023);
      update(1023, 32'sh1234_5678);
      query(1000, 1023);

      random_phase(31, 51, 11'd1024, 32'sh7FFF_FFFF);
      random_phase(51, 31, 11'($urandom_range(48, 2)), VAL_W'($urandom));
      random_phase(0, 0, 11'($urandom_range(1023, 1)), 32'sh8000_0000);

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
